// ===== sv/rhp_pkg.sv =====
// Package for the RTP header parser: shared constants, status codes and the
// event record passed from the parsing front end to the result back end.
// No dependencies; every other file of the block but rhp_ifs.sv imports it.
package rhp_pkg;

  localparam int HDR_BYTES            = 12;
  localparam int DEF_MAX_PACKET_BYTES = 65535;
  localparam int DEF_QUEUE_DEPTH      = 4;

  localparam logic [16:0] HDR_END_MAX = 17'h1FFFF;
  localparam logic [15:0] POS_MAX     = 16'hFFFF;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT_HDR  = 3'd1;
  localparam logic [2:0] ST_SHORT_CSRC = 3'd2;
  localparam logic [2:0] ST_SHORT_EXT  = 3'd3;
  localparam logic [2:0] ST_BAD_PAD    = 3'd4;
  localparam logic [2:0] ST_TOO_LONG   = 3'd5;

  localparam logic KIND_CSRC    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [1:0]  version;
    logic        marker;
    logic [6:0]  payload_type;
    logic [15:0] sequence_res;
    logic [31:0] timestamp;
    logic [31:0] sync_source;
    logic [3:0]  source_count;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [2:0]  status;
  } summary_t;

  typedef struct packed {
    logic        csrc_vld;
    logic [31:0] csrc_word;
    logic        sum_vld;
    summary_t    summary;
  } event_t;

  typedef struct packed {
    logic push;
    logic full;
  } push_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } pop_ctl_t;

endpackage

// ===== sv/rhp_ifs.sv =====
// Valid/ready channel interfaces of the RTP header parser: the packet byte
// stream and the result stream. No dependencies.
interface rhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rhp_result_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [31:0] source_word;
  logic [1:0]  version;
  logic        marker;
  logic [6:0]  payload_type;
  logic [15:0] sequence_res;
  logic [31:0] timestamp;
  logic [31:0] sync_source;
  logic [3:0]  source_count;
  logic [15:0] payload_offset;
  logic [15:0] payload_length;
  logic [2:0]  status;

  modport source (
    output valid, output result_kind, output source_word, output version,
    output marker, output payload_type, output sequence_res, output timestamp,
    output sync_source, output source_count, output payload_offset,
    output payload_length, output status, input ready
  );
  modport sink (
    input valid, input result_kind, input source_word, input version,
    input marker, input payload_type, input sequence_res, input timestamp,
    input sync_source, input source_count, input payload_offset,
    input payload_length, input status, output ready
  );
endinterface

// ===== sv/rhp_front.sv =====
// Front end of the RTP header parser: takes one packet byte per transfer,
// tracks header state and builds CSRC and end-of-packet events.
// Depends on rhp_pkg and rhp_byte_if.
module rhp_front #(
  parameter int MAX_PACKET_BYTES = rhp_pkg::DEF_MAX_PACKET_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  rhp_byte_if.sink           pkt,
  output rhp_pkg::event_t    ev,
  output rhp_pkg::push_ctl_t push_ctl,
  input  logic               full
);
  import rhp_pkg::*;

  logic [15:0] byte_position;
  logic [31:0] assembly_word;
  logic [31:0] header_first_word;
  logic [31:0] held_timestamp;
  logic [31:0] held_sync_source;
  logic [16:0] header_end;
  logic        overflow_flag;

  logic        accept;
  logic [15:0] p;
  logic [15:0] pos_next;
  logic [31:0] aw_next;
  logic [31:0] hfw_next;
  logic [31:0] ts_next;
  logic [31:0] ssrc_next;
  logic        ovf_next;
  logic [3:0]  cc;
  logic        ext_bit;
  logic        pad_bit;
  logic [6:0]  list_end;
  logic [16:0] he_base;
  logic [18:0] ext_sum;
  logic [16:0] he_ext;
  logic        ext_now;
  logic [16:0] header_end_next;
  logic        csrc_now;
  logic [16:0] len;
  logic [16:0] rem;
  logic [16:0] rem_pad;
  logic [2:0]  st;

  assign accept = pkt.valid && pkt.ready;
  assign pkt.ready = !full;
  assign p = byte_position;

  always_comb begin
    aw_next   = {assembly_word[23:0], pkt.data_byte};
    ovf_next  = overflow_flag || (p >= 16'(MAX_PACKET_BYTES));
    pos_next  = (p != POS_MAX) ? p + 16'd1 : p;
    hfw_next  = (p == 16'd3) ? aw_next : header_first_word;
    ts_next   = (p == 16'd7) ? aw_next : held_timestamp;
    ssrc_next = (p == 16'd11) ? aw_next : held_sync_source;
    cc        = hfw_next[27:24];
    ext_bit   = hfw_next[28];
    pad_bit   = hfw_next[29];
    list_end  = 7'(HDR_BYTES) + {1'b0, cc, 2'b00};
    he_base   = (p == 16'd3) ? 17'(list_end) + (ext_bit ? 17'd4 : 17'd0) : header_end;
    ext_now   = ext_bit && (p >= 16'd4) && (p == 16'(list_end) + 16'd3);
    ext_sum   = {2'b00, he_base} + {1'b0, aw_next[15:0], 2'b00};
    he_ext    = (ext_sum > {2'b00, HDR_END_MAX}) ? HDR_END_MAX : ext_sum[16:0];
    header_end_next = ext_now ? he_ext : he_base;
    csrc_now  = !ovf_next && (p >= 16'd15) && (p < 16'(list_end)) && (p[1:0] == 2'b11);
    len       = {1'b0, p} + 17'd1;
    rem       = len - header_end_next;
    rem_pad   = rem - 17'(pkt.data_byte);

    if (ovf_next) begin
      st = ST_TOO_LONG;
    end else if (len < 17'(HDR_BYTES)) begin
      st = ST_SHORT_HDR;
    end else if (len < 17'(list_end)) begin
      st = ST_SHORT_CSRC;
    end else if (ext_bit && ((len < 17'(list_end) + 17'd4) || (len < header_end_next))) begin
      st = ST_SHORT_EXT;
    end else if (pad_bit && ((rem == 17'd0) || (17'(pkt.data_byte) > rem))) begin
      st = ST_BAD_PAD;
    end else begin
      st = ST_OK;
    end

    ev = '0;
    ev.csrc_vld  = csrc_now;
    ev.csrc_word = aw_next;
    ev.sum_vld   = pkt.last_byte;
    if (st != ST_SHORT_HDR) begin
      ev.summary.version      = hfw_next[31:30];
      ev.summary.marker       = hfw_next[23];
      ev.summary.payload_type = hfw_next[22:16];
      ev.summary.sequence_res = hfw_next[15:0];
      ev.summary.timestamp    = ts_next;
      ev.summary.sync_source  = ssrc_next;
      ev.summary.source_count = cc;
    end
    if (st == ST_OK) begin
      ev.summary.payload_offset = header_end_next[15:0];
      ev.summary.payload_length = pad_bit ? rem_pad[15:0] : rem[15:0];
    end
    ev.summary.status = st;

    push_ctl.push = accept && (csrc_now || pkt.last_byte);
    push_ctl.full = full;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && pkt.last_byte)) begin
      byte_position     <= '0;
      assembly_word     <= '0;
      header_first_word <= '0;
      held_timestamp    <= '0;
      held_sync_source  <= '0;
      header_end        <= 17'(HDR_BYTES);
      overflow_flag     <= 1'b0;
    end else if (accept) begin
      byte_position     <= pos_next;
      assembly_word     <= aw_next;
      header_first_word <= hfw_next;
      held_timestamp    <= ts_next;
      held_sync_source  <= ssrc_next;
      header_end        <= header_end_next;
      overflow_flag     <= ovf_next;
    end
  end

endmodule

// ===== sv/rhp_queue.sv =====
// Event queue between the front end and the back end of the RTP header
// parser, so that each side can stall on its own. Depends on rhp_pkg.
module rhp_queue #(
  parameter int DEPTH = rhp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  rhp_pkg::push_ctl_t push_ctl,
  input  rhp_pkg::event_t    wr_data,
  output logic               full,
  input  logic               pop,
  output rhp_pkg::pop_ctl_t  pop_ctl,
  output rhp_pkg::event_t    rd_data
);
  import rhp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  event_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;

  assign push      = push_ctl.push && !push_ctl.full;
  assign full      = (count == CW'(DEPTH));
  assign rd_data   = mem[rd_ptr];
  assign pop_ctl.pop   = pop;
  assign pop_ctl.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from empty queue");
  a_count_grow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CW'(1)))
    else $error("count did not grow on push");

endmodule

// ===== sv/rhp_back.sv =====
// Back end of the RTP header parser: takes events from the queue and hands
// out one result per transfer, a CSRC word before a summary of the same byte.
// Depends on rhp_pkg and rhp_result_if.
module rhp_back (
  input  logic              clk,
  input  logic              rst,
  input  rhp_pkg::event_t   ev,
  input  rhp_pkg::pop_ctl_t pop_ctl,
  output logic              pop,
  rhp_result_if.source      res
);
  import rhp_pkg::*;

  event_t rec;
  logic   rec_vld;
  logic   done;
  logic   show_csrc;

  assign show_csrc = rec.csrc_vld;
  assign done = rec_vld && res.ready && !(rec.csrc_vld && rec.sum_vld);
  assign pop  = !pop_ctl.empty && (!rec_vld || done);

  always_comb begin
    res.valid          = rec_vld;
    res.result_kind    = show_csrc ? KIND_CSRC : KIND_SUMMARY;
    res.source_word    = show_csrc ? rec.csrc_word : '0;
    res.version        = show_csrc ? '0 : rec.summary.version;
    res.marker         = show_csrc ? '0 : rec.summary.marker;
    res.payload_type   = show_csrc ? '0 : rec.summary.payload_type;
    res.sequence_res   = show_csrc ? '0 : rec.summary.sequence_res;
    res.timestamp      = show_csrc ? '0 : rec.summary.timestamp;
    res.sync_source    = show_csrc ? '0 : rec.summary.sync_source;
    res.source_count   = show_csrc ? '0 : rec.summary.source_count;
    res.payload_offset = show_csrc ? '0 : rec.summary.payload_offset;
    res.payload_length = show_csrc ? '0 : rec.summary.payload_length;
    res.status         = show_csrc ? ST_OK : rec.summary.status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_vld <= 1'b0;
    end else if (pop_ctl.pop) begin
      rec     <= ev;
      rec_vld <= 1'b1;
    end else if (done) begin
      rec_vld <= 1'b0;
    end else if (rec_vld && res.ready) begin
      rec.csrc_vld <= 1'b0;
    end
  end

  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    (rec_vld && rec.csrc_vld && rec.sum_vld && res.ready) |=>
    (res.valid && (res.result_kind == KIND_SUMMARY)))
    else $error("summary lost after CSRC transfer");
  a_error_no_length: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.status != ST_OK)) |->
    ((res.payload_length == '0) && (res.payload_offset == '0)))
    else $error("payload reported with error status");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    (pop && rec_vld) |-> done)
    else $error("event popped over a pending result");

endmodule

// ===== sv/rtp_header_parser.sv =====
// RTP header parser. Takes one packet byte per clock while the queue is not
// full; a CSRC word is queued when its fourth byte is transferred and then
// held in the back end's result register, the summary likewise with the last
// byte, behind the CSRC result when that byte ends a word. The byte-wide front
// end sets the throughput and updates all header state in the cycle a byte is
// transferred; results wait in a small event queue, so the input keeps
// flowing while the result side stalls until the queue fills.
// Depends on rhp_pkg, rhp_ifs, rhp_front, rhp_queue and rhp_back.
module rtp_header_parser #(
  parameter int MAX_PACKET_BYTES = rhp_pkg::DEF_MAX_PACKET_BYTES,
  parameter int QUEUE_DEPTH      = rhp_pkg::DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  rhp_byte_if.sink     pkt,
  rhp_result_if.source res
);
  import rhp_pkg::*;

  event_t    ev_in;
  event_t    ev_out;
  push_ctl_t push_ctl;
  pop_ctl_t  pop_ctl;
  logic      full;
  logic      pop;

  rhp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt),
    .ev       (ev_in),
    .push_ctl (push_ctl),
    .full     (full)
  );

  rhp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_ctl (push_ctl),
    .wr_data  (ev_in),
    .full     (full),
    .pop      (pop),
    .pop_ctl  (pop_ctl),
    .rd_data  (ev_out)
  );

  rhp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .ev      (ev_out),
    .pop_ctl (pop_ctl),
    .pop     (pop),
    .res     (res)
  );

endmodule
